/* rtl/kalman_filter_const_velocity_core_macros.svh */
// Assertion macros shared by the RTL.
// KF_ASSERT expects clk and rst_n in scope, KF_ASSERT_RST only clk.
`ifndef KALMAN_FILTER_CONST_VELOCITY_CORE_MACROS_SVH
`define KALMAN_FILTER_CONST_VELOCITY_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KF_ASSERT(lbl, prop, msg)
`define KF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/kfcv_pkg.sv */
package kfcv_pkg;
  localparam int W   = 32;          // estimate / covariance word
  localparam int CFB = 28;          // covariance fraction bits
  localparam int EW  = W + 1;       // multiplier operand width
  localparam int PW  = 2 * EW;      // full product width
  localparam int RW  = PW - CFB;    // rounded product width
  localparam int NW  = W + CFB;     // dividend magnitude width
  localparam int CW  = $clog2(NW);  // divider step counter
  localparam int RGW = W - 1;       // config register width

  localparam logic signed [W-1:0] COV_ONE = W'(64'd1 << CFB);
  localparam logic [RGW-1:0] Q_RESET = RGW'(26844);
  localparam logic [RGW-1:0] R_RESET = RGW'(64'd1 << CFB);

  typedef enum logic [1:0] {
    REG_Q_POS  = 2'd0,
    REG_Q_VEL  = 2'd1,
    REG_R_MEAS = 2'd2
  } cfg_reg_t;

  // divider result word
  typedef struct packed {
    logic                done;
    logic signed [W-1:0] quot;
  } div_res_t;

  // clamp to the signed word range
  function automatic logic signed [W-1:0] sat_w(input logic signed [71:0] v);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = (72'sd1 <<< (W - 1)) - 72'sd1;
    lo = -hi - 72'sd1;
    if (v > hi) return hi[W-1:0];
    else if (v < lo) return lo[W-1:0];
    else return v[W-1:0];
  endfunction
endpackage

/* rtl/kfcv_in_if.sv */
interface kfcv_in_if;
  import kfcv_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [W-1:0] measurement;
  logic                restart;
  modport source(output valid, measurement, restart, input ready);
  modport sink(input valid, measurement, restart, output ready);
endinterface

/* rtl/kfcv_out_if.sv */
interface kfcv_out_if;
  import kfcv_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [W-1:0] position_out;
  logic signed [W-1:0] velocity_out;
  modport source(output valid, position_out, velocity_out, input ready);
  modport sink(input valid, position_out, velocity_out, output ready);
endinterface

/* rtl/kfcv_div.sv */
// Restoring signed divider, one quotient bit a cycle, saturated result
module kfcv_div import kfcv_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [NW:0]  num,
  input  logic signed [W+1:0] den,
  output div_res_t            res
);
  logic            busy_r;
  logic            fin_r;
  logic [CW-1:0]   cnt_r;
  logic [NW-1:0]   nmag_r;
  logic [W:0]      dmag_r;
  logic [W:0]      rem_r;
  logic [NW-1:0]   quo_r;
  logic            neg_r;
  div_res_t        res_r;

  logic [W+1:0]    shifted;
  logic [W+1:0]    diff;
  logic            qbit;
  logic signed [NW:0]  num_abs;
  logic signed [W+1:0] den_abs;
  logic signed [NW:0]  q_signed;

  assign num_abs  = num[NW] ? -num : num;
  assign den_abs  = den[W+1] ? -den : den;
  assign shifted  = {rem_r, nmag_r[NW-1]};
  assign diff     = shifted - {1'b0, dmag_r};
  assign qbit     = (shifted >= {1'b0, dmag_r});
  assign q_signed = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign res      = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      fin_r      <= 1'b0;
      res_r.done <= 1'b0;
    end else begin
      res_r.done <= 1'b0;
      fin_r      <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW - 1);
        nmag_r <= num_abs[NW-1:0];
        dmag_r <= den_abs[W:0];
        rem_r  <= '0;
        neg_r  <= num[NW] ^ den[W+1];
      end else if (busy_r) begin
        // one restoring step
        rem_r  <= qbit ? diff[W:0] : shifted[W:0];
        quo_r  <= {quo_r[NW-2:0], qbit};
        nmag_r <= {nmag_r[NW-2:0], 1'b0};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      // sign fix and clamp
      if (fin_r) begin
        res_r.done <= 1'b1;
        res_r.quot <= sat_w(72'(q_signed));
      end
    end
  end
endmodule

/* rtl/kfcv_mul.sv */
// Shared multiplier: registered product, rounded half up
module kfcv_mul import kfcv_pkg::*; (
  input  logic                 clk,
  input  logic signed [EW-1:0] a,
  input  logic signed [EW-1:0] b,
  output logic signed [RW-1:0] rnd
);
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] biased;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign biased = prod_r + (PW'(1) <<< (CFB - 1));
  assign rnd    = biased[PW-1:CFB];
endmodule

/* rtl/kalman_filter_const_velocity_core.sv */
// Two-state constant-velocity Kalman filter, one position sample per word.
// in_ch carries measurement (signed Q16.16) and restart; out_ch returns the
// corrected position and velocity (signed Q16.16, saturated), one word per
// input word, in order. Both channels are valid/ready.
// cfg_we/cfg_idx/cfg_data write q_pos, q_vel, r_meas (index 0..2, unsigned Q3.28);
// write only while the block is idle.
// Each word passes three prediction states (S_PRED1..S_PRED3), two
// divisions on one restoring divider (60 quotient bits at one bit a cycle),
// five products on one shared multiplier (each through S_MISS and S_MWB)
// and S_DONE, which hands the result to the output register.
// in_ch.ready is high only between words, so a new word is not taken
// until the last one has left S_DONE.
// The result sits in an output register; a stalled receiver only holds
// the next word at its final step until the register frees.
// Reset clears the estimates, sets the covariance to identity and loads
// the noise registers with their defaults; restart does the same to the
// filter state (not the registers) before its own sample.
`include "kalman_filter_const_velocity_core_macros.svh"
module kalman_filter_const_velocity_core import kfcv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  kfcv_in_if.sink          in_ch,
  kfcv_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [RGW-1:0]   cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_PRED1, S_PRED2, S_PRED3, S_DIV0, S_DIV1, S_MISS, S_MWB, S_DONE
  } state_t;

  state_t state_r;

  logic [RGW-1:0] q_pos_r, q_vel_r, r_meas_r;
  logic signed [W-1:0] pos_est_r, vel_est_r, cov_pp_r, cov_pv_r, cov_vv_r;
  logic signed [W-1:0] z_r, xp_r, pp00_r, pp01_r, pp11_r, k0_r, k1_r;
  logic signed [W+1:0] tmp_r;
  logic signed [EW-1:0] e_r, omk_r;
  logic [2:0] step_r;
  logic out_valid_r;
  logic signed [W-1:0] out_pos_r, out_vel_r;

  logic signed [W+1:0] s_c;
  logic                s_zero;
  logic                div_start;
  logic signed [NW:0]  div_num;
  div_res_t            div_res;
  logic signed [W-1:0] gain;
  logic signed [EW-1:0] ma, mb;
  logic signed [RW-1:0] m_rnd;

  // innovation variance and gain selection
  assign s_c    = (W+2)'(pp00_r) + $signed({3'b0, r_meas_r});
  assign s_zero = (s_c == '0);
  assign gain   = s_zero ? '0 : div_res.quot;

  assign div_start = (state_r == S_PRED3) || (state_r == S_DIV0 && div_res.done);
  assign div_num   = (state_r == S_PRED3) ? ((NW+1)'(pp00_r) <<< CFB)
                                          : ((NW+1)'(pp01_r) <<< CFB);

  kfcv_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(div_num), .den(s_c), .res(div_res)
  );

  // multiplier operand select
  always_comb begin
    case (step_r)
      3'd0:    begin ma = EW'(k0_r); mb = e_r;          end
      3'd1:    begin ma = EW'(k1_r); mb = e_r;          end
      3'd2:    begin ma = omk_r;     mb = EW'(pp00_r);  end
      3'd3:    begin ma = omk_r;     mb = EW'(pp01_r);  end
      3'd4:    begin ma = EW'(k1_r); mb = EW'(pp01_r);  end
      default: begin ma = '0;        mb = '0;           end
    endcase
  end

  kfcv_mul u_mul (.clk(clk), .a(ma), .b(mb), .rnd(m_rnd));

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.position_out = out_pos_r;
  assign out_ch.velocity_out = out_vel_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_pos_r  <= Q_RESET;
      q_vel_r  <= Q_RESET;
      r_meas_r <= R_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_Q_POS:  q_pos_r  <= cfg_data;
        REG_Q_VEL:  q_vel_r  <= cfg_data;
        REG_R_MEAS: r_meas_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      pos_est_r   <= '0;
      vel_est_r   <= '0;
      cov_pp_r    <= COV_ONE;
      cov_pv_r    <= '0;
      cov_vv_r    <= COV_ONE;
    end else begin
      // S_DONE reloads the register itself
      if (out_valid_r && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            z_r <= in_ch.measurement;
            if (in_ch.restart) begin
              pos_est_r <= '0;
              vel_est_r <= '0;
              cov_pp_r  <= COV_ONE;
              cov_pv_r  <= '0;
              cov_vv_r  <= COV_ONE;
            end
            state_r <= S_PRED1;
          end
        end
        S_PRED1: begin
          xp_r   <= sat_w(72'(pos_est_r) + 72'(vel_est_r));
          pp01_r <= sat_w(72'(cov_pv_r) + 72'(cov_vv_r));
          pp11_r <= sat_w(72'(cov_vv_r) + $signed({41'b0, q_vel_r}));
          tmp_r  <= (W+2)'(cov_pp_r) + ((W+2)'(cov_pv_r) <<< 1);
          state_r <= S_PRED2;
        end
        S_PRED2: begin
          pp00_r <= sat_w(72'(tmp_r) + 72'(cov_vv_r) + $signed({41'b0, q_pos_r}));
          state_r <= S_PRED3;
        end
        S_PRED3: begin
          e_r     <= EW'(z_r) - EW'(xp_r);
          state_r <= S_DIV0;
        end
        S_DIV0: begin
          if (div_res.done) begin
            k0_r    <= gain;
            omk_r   <= EW'(COV_ONE) - EW'(gain);
            state_r <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_res.done) begin
            k1_r    <= gain;
            step_r  <= '0;
            state_r <= S_MISS;
          end
        end
        S_MISS: state_r <= S_MWB;
        S_MWB: begin
          // write back the rounded product of this step
          case (step_r)
            3'd0:    pos_est_r <= sat_w(72'(xp_r) + 72'(m_rnd));
            3'd1:    vel_est_r <= sat_w(72'(vel_est_r) + 72'(m_rnd));
            3'd2:    cov_pp_r  <= sat_w(72'(m_rnd));
            3'd3:    cov_pv_r  <= sat_w(72'(m_rnd));
            3'd4:    cov_vv_r  <= sat_w(72'(pp11_r) - 72'(m_rnd));
            default: ;
          endcase
          if (step_r == 3'd4) begin
            state_r <= S_DONE;
          end else begin
            step_r  <= step_r + 3'd1;
            state_r <= S_MISS;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_pos_r   <= pos_est_r;
            out_vel_r   <= vel_est_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `KF_ASSERT(a_div_done_when_waiting, div_res.done |-> (state_r == S_DIV0 || state_r == S_DIV1), "divider finished outside a division step")
  `KF_ASSERT(a_accept_starts_predict, (in_ch.valid && in_ch.ready) |=> (state_r == S_PRED1), "accepted word did not start prediction")
  `KF_ASSERT(a_step_range, (state_r == S_MWB) |-> (step_r <= 3'd4), "multiply step out of range")
  `KF_ASSERT_RST(a_reset_cov, !rst_n |=> (cov_pp_r == COV_ONE && cov_vv_r == COV_ONE), "covariance not identity after reset")
endmodule
